// ----- rtl/core/hlw_pkg.sv -----
// hlw_pkg: shared types and constants for the heartbeat loss watchdog
// no dependencies; imported by hlw_cfg_regs, hlw_core and the top level
`timescale 1ns / 1ps

package hlw_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned TallyW = 8;

  localparam logic [TallyW-1:0] TallyMax = {TallyW{1'b1}};

  // reset values of the configuration registers
  localparam logic [TimeW-1:0]  TimeoutRst    = 32'd1000;
  localparam logic [TimeW-1:0]  HysteresisRst = 32'd200;
  localparam logic [TallyW-1:0] ConfirmRst    = 8'd3;
  localparam logic [TimeW-1:0]  RecoveryRst   = 32'd5000;

  typedef enum logic [1:0] {
    CfgTimeout    = 2'd0,
    CfgHysteresis = 2'd1,
    CfgConfirm    = 2'd2,
    CfgRecovery   = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    ReqHeartbeat = 1'b0,
    ReqCheck     = 1'b1
  } req_type_e;

  typedef struct packed {
    logic [TimeW-1:0]  timeout_ms;
    logic [TimeW-1:0]  hysteresis_ms;
    logic [TallyW-1:0] confirm_count;
    logic [TimeW-1:0]  recovery_ms;
  } cfg_t;

  typedef struct packed {
    logic              stop_event;
    logic              exit_stop_event;
    logic              recovery_started;
    logic              link_up;
    logic              stopped;
    logic [TallyW-1:0] confirms;
  } result_t;

endpackage

// ----- rtl/core/heartbeat_loss_watchdog_unit.sv -----
// heartbeat_loss_watchdog_unit: top level of the heartbeat loss watchdog
// depends on hlw_pkg, hlw_cfg_regs and hlw_core
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+-------------------------------------
//  in       | sink      | in_valid_i / in_stall_o | req_type_i, now_ms_i
//  out      | source    | out_valid_o / out_stall_i | stop_event_o .. confirms_o
//  cfg      | sink      | cfg_we_i (no handshake) | cfg_idx_i, cfg_data_i
//
// one transaction per cycle sustained while the output is not stalled; the result passes
// through the input register, then the result register
// the single-cycle rate is set by the state update: subtract, 33-bit compare, tally step
// reset clears all watchdog state and loads register defaults, no clearing pass
// a stalled output holds its result; the input register takes new work while it is empty
// or while the output register is free or being drained in the same cycle
`timescale 1ns / 1ps

module heartbeat_loss_watchdog_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // configuration write port
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_idx_i,
  input  logic [hlw_pkg::TimeW-1:0] cfg_data_i,
  // input channel
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      req_type_i,
  input  logic [hlw_pkg::TimeW-1:0] now_ms_i,
  // output channel
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic                      stop_event_o,
  output logic                      exit_stop_event_o,
  output logic                      recovery_started_o,
  output logic                      link_up_o,
  output logic                      stopped_o,
  output logic [hlw_pkg::TallyW-1:0] confirms_o
);
  import hlw_pkg::*;

  cfg_t    cfg;
  result_t res;

  // input register
  logic             s1_valid_q;
  logic             s1_type_q;
  logic [TimeW-1:0] s1_now_q;

  // result register
  logic    out_valid_q;
  result_t out_res_q;

  logic out_free;   // result register can take a new result this cycle
  logic advance;    // input register hands its transaction to the core
  logic in_accept;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign advance   = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_accept = in_valid_i && !in_stall_o;

  hlw_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  hlw_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (advance),
    .req_type_i (s1_type_q),
    .now_ms_i   (s1_now_q),
    .cfg_i      (cfg),
    .res_o      (res)
  );

  // input register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  // input payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_type_q <= req_type_i;
      s1_now_q  <= now_ms_i;
    end
  end

  // result register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= advance;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign stop_event_o       = out_res_q.stop_event;
  assign exit_stop_event_o  = out_res_q.exit_stop_event;
  assign recovery_started_o = out_res_q.recovery_started;
  assign link_up_o          = out_res_q.link_up;
  assign stopped_o          = out_res_q.stopped;
  assign confirms_o         = out_res_q.confirms;

  // a stop and an exit never come from the same transaction
  a_no_stop_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_res_q.stop_event && out_res_q.exit_stop_event))
    else $error("stop and exit in one result");

  // a stop result reports stopped, link down and a cleared tally
  a_stop_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_res_q.stop_event |->
      out_res_q.stopped && !out_res_q.link_up && out_res_q.confirms == '0)
    else $error("inconsistent stop result");

  // the input register never drops a transaction while the output is stalled
  a_hold_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && out_valid_q && out_stall_i |=> s1_valid_q && $stable(s1_now_q))
    else $error("input register lost a transaction under stall");

endmodule

// ----- rtl/core/hlw_cfg_regs.sv -----
// hlw_cfg_regs: configuration register file of the watchdog
// depends on hlw_pkg
`timescale 1ns / 1ps

module hlw_cfg_regs (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [1:0]              cfg_idx_i,
  input  logic [hlw_pkg::TimeW-1:0] cfg_data_i,
  output hlw_pkg::cfg_t           cfg_o
);
  import hlw_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.timeout_ms    <= TimeoutRst;
      cfg_q.hysteresis_ms <= HysteresisRst;
      cfg_q.confirm_count <= ConfirmRst;
      cfg_q.recovery_ms   <= RecoveryRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgTimeout:    cfg_q.timeout_ms    <= cfg_data_i;
        CfgHysteresis: cfg_q.hysteresis_ms <= cfg_data_i;
        CfgConfirm:    cfg_q.confirm_count <= cfg_data_i[TallyW-1:0];
        CfgRecovery:   cfg_q.recovery_ms   <= cfg_data_i;
        default:       ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/core/hlw_core.sv -----
// hlw_core: watchdog state and the single-pass update for one transaction
// depends on hlw_pkg
`timescale 1ns / 1ps

module hlw_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      step_i,
  input  logic                      req_type_i,
  input  logic [hlw_pkg::TimeW-1:0] now_ms_i,
  input  hlw_pkg::cfg_t             cfg_i,
  output hlw_pkg::result_t          res_o
);
  import hlw_pkg::*;

  logic [TimeW-1:0]  last_beat_q, last_beat_d;
  logic [TimeW-1:0]  stop_start_q, stop_start_d;
  logic [TallyW-1:0] tally_q, tally_d;
  logic              conn_q, conn_d;
  logic              stop_q, stop_d;

  logic [TimeW-1:0]  elapsed;
  logic [TimeW-1:0]  since_stop;
  logic [TimeW:0]    limit;
  logic [TallyW-1:0] tally_inc;
  logic              over_limit;
  logic              within_timeout;
  logic              trig;
  logic              ev_stop, ev_exit, ev_rec;

  assign elapsed        = now_ms_i - last_beat_q;
  assign since_stop     = now_ms_i - stop_start_q;
  assign limit          = {1'b0, cfg_i.timeout_ms} + {1'b0, cfg_i.hysteresis_ms};
  assign over_limit     = {1'b0, elapsed} > limit;
  assign within_timeout = elapsed <= cfg_i.timeout_ms;
  assign tally_inc      = (tally_q == TallyMax) ? TallyMax : tally_q + 1'b1;
  assign trig           = tally_inc >= cfg_i.confirm_count;

  always_comb begin
    last_beat_d  = last_beat_q;
    stop_start_d = stop_start_q;
    tally_d      = tally_q;
    conn_d       = conn_q;
    stop_d       = stop_q;
    ev_stop      = 1'b0;
    ev_exit      = 1'b0;
    ev_rec       = 1'b0;
    unique case (req_type_e'(req_type_i))
      ReqHeartbeat: begin
        last_beat_d = now_ms_i;
        tally_d     = '0;
        conn_d      = 1'b1;
        if (!conn_q && stop_q) begin
          stop_start_d = now_ms_i;
          ev_rec       = 1'b1;
        end
      end
      ReqCheck: begin
        if (conn_q && over_limit) begin
          tally_d = tally_inc;
          if (trig) begin
            conn_d       = 1'b0;
            stop_d       = 1'b1;
            stop_start_d = now_ms_i;
            tally_d      = '0;
            ev_stop      = 1'b1;
          end
        end else if (conn_q && within_timeout) begin
          tally_d = '0;
        end
        // a stop in this same check drops the link, so exit cannot follow it
        if (stop_d && conn_d && since_stop >= cfg_i.recovery_ms) begin
          stop_d  = 1'b0;
          ev_exit = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_beat_q  <= '0;
      stop_start_q <= '0;
      tally_q      <= '0;
      conn_q       <= 1'b0;
      stop_q       <= 1'b0;
    end else if (step_i) begin
      last_beat_q  <= last_beat_d;
      stop_start_q <= stop_start_d;
      tally_q      <= tally_d;
      conn_q       <= conn_d;
      stop_q       <= stop_d;
    end
  end

  assign res_o.stop_event       = ev_stop;
  assign res_o.exit_stop_event  = ev_exit;
  assign res_o.recovery_started = ev_rec;
  assign res_o.link_up          = conn_d;
  assign res_o.stopped          = stop_d;
  assign res_o.confirms         = tally_d;

  // a stop always leaves the block stopped with the link down
  a_stop_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && ev_stop |=> stop_q && !conn_q)
    else $error("stop event did not leave block stopped and disconnected");

  // an exit clears the stop flag on the next cycle
  a_exit_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && ev_exit |=> !stop_q && conn_q)
    else $error("exit event did not clear the stop");

  // a heartbeat never counts toward a stop
  a_beat_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && req_type_i == ReqHeartbeat |=> tally_q == '0 && conn_q)
    else $error("heartbeat did not clear tally and mark link up");

  // recovery timer only restarts when stopped
  a_rec_stopped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && ev_rec |-> stop_q && !conn_q)
    else $error("recovery restart while not stopped or link up");

endmodule

// ----- dv/tb_top.sv -----
// tb_top: self-checking testbench for heartbeat_loss_watchdog_unit
// depends on hlw_pkg and the watchdog rtl; drives heartbeats, checks and register writes,
// predicts every result in-line and compares the prediction, or a typed result where given, field by field
`timescale 1ns / 1ps

module tb_top;
  import hlw_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldAt     = 1350;  // transactions sent before the long hold-off
  localparam int unsigned HoldCycles = 120;
  localparam int unsigned DrainWait  = 8;

  // one directed transaction, with a typed result where it is obvious
  typedef struct {
    req_type_e        kind;
    logic [TimeW-1:0] now;
    bit               typed;
    result_t          want;
  } dir_row_t;

  // one register setting plus the shape of the traffic run under it
  typedef struct {
    logic [TimeW-1:0]  timeout;
    logic [TimeW-1:0]  hyst;
    logic [TallyW-1:0] confirm;
    logic [TimeW-1:0]  recovery;
    int unsigned       span;      // largest forward step of the time stamp
    int unsigned       hb_pct;    // share of heartbeats
    int unsigned       edge_pct;  // share of time stamps placed on a threshold
    int unsigned       n_items;
    bit                lead_hb;   // open the phase with a heartbeat
    bit                busy;      // no idling on either side
  } phase_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [1:0]        cfg_idx_i = '0;
  logic [TimeW-1:0]  cfg_data_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic              req_type_i = 1'b0;
  logic [TimeW-1:0]  now_ms_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic              stop_event_o;
  logic              exit_stop_event_o;
  logic              recovery_started_o;
  logic              link_up_o;
  logic              stopped_o;
  logic [TallyW-1:0] confirms_o;

  // predictor state and its copy of the registers
  cfg_t              wd_cfg;
  logic [TimeW-1:0]  beat_ts;
  logic [TallyW-1:0] tally;
  logic              link;
  logic              halted;
  logic [TimeW-1:0]  halt_ts;

  result_t     pending_results[$];
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned items_sent = 0;
  int unsigned cycle_count = 0;
  bit          steady = 1'b0;    // both sides stop idling
  bit          hold_off = 1'b0;  // receiver holds the output channel

  heartbeat_loss_watchdog_unit dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .req_type_i         (req_type_i),
    .now_ms_i           (now_ms_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .stop_event_o       (stop_event_o),
    .exit_stop_event_o  (exit_stop_event_o),
    .recovery_started_o (recovery_started_o),
    .link_up_o          (link_up_o),
    .stopped_o          (stopped_o),
    .confirms_o         (confirms_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // directed opening, all under the reset register values (1000 / 200 / 3 / 5000)
  dir_row_t opening_seq [23] = '{
    // checks while disconnected touch nothing
    '{ReqCheck,     32'd0,         1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0}},
    '{ReqCheck,     32'hFFFF_FFFF, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0}},
    '{ReqHeartbeat, 32'd100,       1'b1, '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 8'd0}},
    // silence exactly at the timeout clears the tally
    '{ReqCheck,     32'd1100,      1'b1, '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 8'd0}},
    // exactly at the threshold sum: between the limits, tally held
    '{ReqCheck,     32'd1300,      1'b0, '0},
    '{ReqCheck,     32'd1301,      1'b1, '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 8'd1}},
    '{ReqCheck,     32'd1250,      1'b0, '0},
    '{ReqCheck,     32'd1400,      1'b0, '0},
    // third confirmation raises the stop and drops the link
    '{ReqCheck,     32'd2000,      1'b1, '{1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 8'd0}},
    '{ReqCheck,     32'd9000,      1'b0, '0},
    // reconnect while stopped restarts recovery, a second beat does not
    '{ReqHeartbeat, 32'd9100,      1'b1, '{1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 8'd0}},
    '{ReqHeartbeat, 32'd9200,      1'b1, '{1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 8'd0}},
    // one short of the recovery time, then exactly on it
    '{ReqCheck,     32'd14099,     1'b0, '0},
    '{ReqCheck,     32'd14100,     1'b0, '0},
    // same story across the wrap of the time stamp
    '{ReqHeartbeat, 32'hFFFF_FF00, 1'b0, '0},
    '{ReqCheck,     32'h0000_02A0, 1'b0, '0},
    '{ReqCheck,     32'h0000_03B0, 1'b0, '0},
    '{ReqCheck,     32'h0000_03B1, 1'b0, '0},
    '{ReqCheck,     32'h0000_03B2, 1'b0, '0},
    '{ReqCheck,     32'h0000_03B3, 1'b0, '0},
    '{ReqHeartbeat, 32'hFFFF_FFFF, 1'b0, '0},
    '{ReqCheck,     32'h0000_1386, 1'b0, '0},
    '{ReqCheck,     32'h0000_1387, 1'b0, '0}
  };

  // register settings for the random part, extremes included
  phase_t plan [9] = '{
    '{32'd50,         32'd20,         8'd2,   32'd100,        60,   25, 20, 250, 1'b1, 1'b1},
    // all zero: any silence is a timeout, recovery is immediate
    '{32'd0,          32'd0,          8'd1,   32'd0,          3,    30, 15, 150, 1'b1, 1'b0},
    // largest values: the 33-bit sum can never be exceeded
    '{32'hFFFF_FFFF,  32'hFFFF_FFFF,  8'd3,   32'hFFFF_FFFF,  1000, 30, 20, 120, 1'b1, 1'b0},
    '{32'hFFFF_FFFE,  32'd0,          8'd1,   32'd10,         1000, 30, 25, 100, 1'b1, 1'b0},
    // largest confirm count: one long silence after a single beat
    '{32'd10,         32'd5,          8'd255, 32'd30,         20,   0,  0,  300, 1'b1, 1'b0},
    // zero confirm count stops on the first timed-out check
    '{32'd100,        32'd50,         8'd0,   32'd200,        150,  30, 20, 150, 1'b1, 1'b0},
    // build a tally under a high count, then lower the count under it
    '{32'd20,         32'd10,         8'd10,  32'd50,         40,   0,  0,  7,   1'b1, 1'b0},
    '{32'd20,         32'd10,         8'd3,   32'd50,         40,   20, 15, 200, 1'b0, 1'b0},
    '{32'd500,        32'd300,        8'd4,   32'd2000,       600,  20, 20, 300, 1'b1, 1'b0}
  };

  // expected outcome of one transaction; advances the predictor state
  function automatic result_t advance_watchdog(req_type_e kind, logic [TimeW-1:0] now);
    result_t          res;
    logic [TimeW-1:0] elapsed;
    logic [TimeW-1:0] since;
    logic [TimeW:0]   limit;
    res = '0;
    if (kind == ReqHeartbeat) begin
      beat_ts = now;
      tally   = '0;
      if (!link && halted) begin
        halt_ts = now;
        res.recovery_started = 1'b1;
      end
      link = 1'b1;
    end else begin
      elapsed = now - beat_ts;
      limit   = {1'b0, wd_cfg.timeout_ms} + {1'b0, wd_cfg.hysteresis_ms};
      if (link && ({1'b0, elapsed} > limit)) begin
        if (tally != TallyMax) tally = tally + 1'b1;
        if (tally >= wd_cfg.confirm_count) begin
          link    = 1'b0;
          halted  = 1'b1;
          halt_ts = now;
          tally   = '0;
          res.stop_event = 1'b1;
        end
      end else if (link && (elapsed <= wd_cfg.timeout_ms)) begin
        tally = '0;
      end
      since = now - halt_ts;
      if (halted && link && (since >= wd_cfg.recovery_ms)) begin
        halted = 1'b0;
        res.exit_stop_event = 1'b1;
      end
    end
    res.link_up   = link;
    res.stopped   = halted;
    res.confirms  = tally;
    return res;
  endfunction

  task automatic flag_mismatch(string what);
    $display("ERROR at %0t, result %0d: %s", $realtime, results_seen, what);
    mismatches++;
  endtask

  task automatic compare_result(result_t got);
    result_t exp_res;
    if (pending_results.size() == 0) begin
      flag_mismatch("result with no transaction outstanding");
      return;
    end
    exp_res = pending_results.pop_front();
    if (got.stop_event !== exp_res.stop_event)
      flag_mismatch($sformatf("stop_event %b, expected %b", got.stop_event,
                              exp_res.stop_event));
    if (got.exit_stop_event !== exp_res.exit_stop_event)
      flag_mismatch($sformatf("exit_stop_event %b, expected %b", got.exit_stop_event,
                              exp_res.exit_stop_event));
    if (got.recovery_started !== exp_res.recovery_started)
      flag_mismatch($sformatf("recovery_started %b, expected %b", got.recovery_started,
                              exp_res.recovery_started));
    if (got.link_up !== exp_res.link_up)
      flag_mismatch($sformatf("link_up %b, expected %b", got.link_up, exp_res.link_up));
    if (got.stopped !== exp_res.stopped)
      flag_mismatch($sformatf("stopped %b, expected %b", got.stopped, exp_res.stopped));
    if (got.confirms !== exp_res.confirms)
      flag_mismatch($sformatf("confirms %0d, expected %0d", got.confirms, exp_res.confirms));
    results_seen++;
  endtask

  // offer one transaction; valid stays high after acceptance so back-to-back
  // transactions never lower and raise it in the same step
  task automatic issue_item(req_type_e kind, logic [TimeW-1:0] now, bit typed,
                            result_t want);
    result_t predicted;
    if (!steady && !hold_off && ($urandom_range(99) < 33)) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 33);
    end
    in_valid_i <= 1'b1;
    req_type_i <= kind;
    now_ms_i   <= now;
    do @(posedge clk_i); while (in_stall_o);
    predicted = advance_watchdog(kind, now);
    pending_results.push_back(typed ? want : predicted);
    items_sent++;
  endtask

  // output side: check accepted results and pick the stall for the next cycle
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i)
        compare_result({stop_event_o, exit_stop_event_o, recovery_started_o,
                        link_up_o, stopped_o, confirms_o});
      if (hold_off) out_stall_i <= 1'b1;
      else if (steady) out_stall_i <= 1'b0;
      else out_stall_i <= ($urandom_range(99) < 33);
    end
  end

  // long receiver hold-off so the result and input registers both fill
  initial begin
    wait (items_sent >= HoldAt);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    phase_t           p;
    req_type_e        kind;
    logic [TimeW-1:0] now;
    logic [TimeW-1:0] clk_ms;
    logic [TimeW-1:0] data;
    logic [TimeW:0]   lim;
    int unsigned      roll;

    // predictor starts from the reset state
    wd_cfg.timeout_ms    = TimeoutRst;
    wd_cfg.hysteresis_ms = HysteresisRst;
    wd_cfg.confirm_count = ConfirmRst;
    wd_cfg.recovery_ms   = RecoveryRst;
    beat_ts = '0;
    tally   = '0;
    link    = 1'b0;
    halted  = 1'b0;
    halt_ts = '0;
    clk_ms  = '0;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (opening_seq[i])
      issue_item(opening_seq[i].kind, opening_seq[i].now, opening_seq[i].typed,
                 opening_seq[i].want);

    foreach (plan[ph]) begin
      p = plan[ph];
      // registers change only with nothing in flight
      in_valid_i <= 1'b0;
      while (pending_results.size() != 0) @(posedge clk_i);
      for (int r = 0; r < 4; r++) begin
        case (cfg_idx_e'(r))
          CfgTimeout: begin
            data = p.timeout;
            wd_cfg.timeout_ms = data;
          end
          CfgHysteresis: begin
            data = p.hyst;
            wd_cfg.hysteresis_ms = data;
          end
          CfgConfirm: begin
            // upper bits are don't-care for the 8-bit register
            data = ($urandom() & 32'hFFFF_FF00) | {24'd0, p.confirm};
            wd_cfg.confirm_count = data[TallyW-1:0];
          end
          default: begin
            data = p.recovery;
            wd_cfg.recovery_ms = data;
          end
        endcase
        cfg_we_i   <= 1'b1;
        cfg_idx_i  <= cfg_idx_e'(r);
        cfg_data_i <= data;
        @(posedge clk_i);
      end
      cfg_we_i <= 1'b0;
      steady   <= p.busy;

      for (int n = 0; n < p.n_items; n++) begin
        if (n == 0 && p.lead_hb) kind = ReqHeartbeat;
        else kind = ($urandom_range(99) < p.hb_pct) ? ReqHeartbeat : ReqCheck;
        roll = $urandom_range(99);
        if (roll < p.edge_pct) begin
          // land right on one of the thresholds the predictor currently sees
          lim = {1'b0, wd_cfg.timeout_ms} + {1'b0, wd_cfg.hysteresis_ms};
          case ($urandom_range(5))
            0:       now = beat_ts + wd_cfg.timeout_ms;
            1:       now = beat_ts + wd_cfg.timeout_ms + 1;
            2:       now = beat_ts + lim[TimeW-1:0];
            3:       now = beat_ts + lim[TimeW-1:0] + 1;
            4:       now = halt_ts + wd_cfg.recovery_ms - 1;
            default: now = halt_ts + wd_cfg.recovery_ms;
          endcase
        end else if (roll < p.edge_pct + 5) begin
          now = $urandom();  // arbitrary jump of the clock
        end else begin
          now = clk_ms + $urandom_range(p.span);
        end
        clk_ms = now;
        issue_item(kind, now, 1'b0, '0);
      end
    end

    in_valid_i <= 1'b0;
    steady     <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    // catch any stray result past the last expected one
    repeat (DrainWait) @(posedge clk_i);
    if (mismatches == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
